// File: rtl/core/semaphore_wait_queue_table_macros.svh
// assertion macros for the semaphore wait queue table
`ifndef SEMAPHORE_WAIT_QUEUE_TABLE_MACROS_SVH
`define SEMAPHORE_WAIT_QUEUE_TABLE_MACROS_SVH
`ifndef SYNTHESIS
`define SWQ_ASSERT_IMP(label, clk, rst, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error(msg);
`define SWQ_ASSERT_NXT(label, clk, rst, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error(msg);
`else
`define SWQ_ASSERT_IMP(label, clk, rst, a, c, msg)
`define SWQ_ASSERT_NXT(label, clk, rst, a, c, msg)
`endif
`endif

// File: rtl/core/swq_pkg.sv
// shared types and constants for the semaphore wait queue table
`timescale 1ns / 1ps
package swq_pkg;
  localparam int NUM_ENTRIES = 16;
  localparam int DW = $clog2(NUM_ENTRIES);
  localparam int NPROC = 16;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;
  localparam logic [1:0] OP_OUT    = 2'd2;
  localparam logic [1:0] OP_HEAD   = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_NOTFOUND = 2'd2;

  typedef struct packed {
    logic [1:0]  operation;
    logic [31:0] key;
    logic [3:0]  process;
  } in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [3:0]  process_out;
    logic [31:0] key_out;
  } out_t;

  // search token passed down the descriptor row
  typedef struct packed {
    logic          hit;
    logic [DW-1:0] hit_idx;
    logic [3:0]    hit_head;
    logic [3:0]    hit_tail;
    logic          free;
    logic [DW-1:0] free_idx;
  } scan_t;

  // update command broadcast to the descriptor row
  typedef struct packed {
    logic          we;
    logic [DW-1:0] idx;
    logic          set_used;
    logic          clr_used;
    logic [31:0]   key;
    logic          wr_head;
    logic [3:0]    head;
    logic          wr_tail;
    logic [3:0]    tail;
  } dcmd_t;
endpackage

// File: rtl/core/swq_cell.sv
// one descriptor cell: holds a key and queue ends, extends the search chain
`timescale 1ns / 1ps
module swq_cell (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [swq_pkg::DW-1:0]      idx,
  input  logic [31:0]                 skey,
  input  swq_pkg::scan_t              sin,
  output swq_pkg::scan_t              sout,
  input  swq_pkg::dcmd_t              cmd
);
  logic        used;
  logic [31:0] key;
  logic [3:0]  head;
  logic [3:0]  tail;

  always_ff @(posedge clk) begin
    if (rst) begin
      used <= 1'b0;
      key  <= '0;
    end else if (cmd.we && cmd.idx == idx) begin
      if (cmd.set_used) begin
        used <= 1'b1;
        key  <= cmd.key;
      end else if (cmd.clr_used) begin
        used <= 1'b0;
        key  <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.we && cmd.idx == idx) begin
      if (cmd.wr_head) head <= cmd.head;
      if (cmd.wr_tail) tail <= cmd.tail;
    end
  end

  // first match and first free win, lower cells sit earlier in the chain
  always_comb begin
    sout = sin;
    if (!sin.hit && used && key == skey && skey != '0) begin
      sout.hit      = 1'b1;
      sout.hit_idx  = idx;
      sout.hit_head = head;
      sout.hit_tail = tail;
    end
    if (!sin.free && !used) begin
      sout.free     = 1'b1;
      sout.free_idx = idx;
    end
  end
endmodule

// File: rtl/core/semaphore_wait_queue_table.sv
// top level of the semaphore wait queue table
`timescale 1ns / 1ps
`include "semaphore_wait_queue_table_macros.svh"
// Pool of NUM_ENTRIES semaphore descriptors kept as a row of cells, each holding
// one key and its queue head and tail; processes 0..15 wait in FIFO order on
// doubly linked lists held in small per-process tables. Every operation passes
// these steps from accept to result: the request is registered on accept, the
// LOOK state looks up the process tables and registers the search key, and the
// EXEC state searches the descriptor row for the key, writes back links and
// registers the result. A new beat is taken as soon as the previous one has left
// the execute step. A finished result waits in the output register while downstream
// stalls, and the execute step holds until that register can take the next one.
module semaphore_wait_queue_table (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  swq_pkg::in_t   in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output swq_pkg::out_t  out_data
);
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_LOOK = 2'd1;
  localparam logic [1:0] S_EXEC = 2'd2;

  logic [1:0]         state;
  swq_pkg::in_t       req;
  logic [31:0]        skey;
  logic [3:0]         pnext [swq_pkg::NPROC];
  logic [3:0]         pprev [swq_pkg::NPROC];
  logic [31:0]        pwkey [swq_pkg::NPROC];
  logic [swq_pkg::NPROC-1:0] pblk;

  swq_pkg::scan_t     chain [swq_pkg::NUM_ENTRIES+1];
  swq_pkg::dcmd_t     cmd;

  logic accept;
  logic exec_go;
  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  // execute only when the output register is empty or being drained
  assign exec_go  = (state == S_EXEC) && (!out_valid || !out_stall);

  assign chain[0] = '0;
  for (genvar g = 0; g < swq_pkg::NUM_ENTRIES; g++) begin : g_cell
    swq_cell u_cell (
      .clk (clk), .rst (rst), .idx (swq_pkg::DW'(g)), .skey (skey),
      .sin (chain[g]), .sout (chain[g+1]), .cmd (cmd)
    );
  end

  swq_pkg::scan_t sr;
  assign sr = chain[swq_pkg::NUM_ENTRIES];

  // execute stage decode
  logic [3:0] tp;
  logic [3:0] nx, pv;
  logic       is_h, is_t, do_unlink, do_ins;
  swq_pkg::out_t res;

  always_comb begin
    cmd = '0;
    res = '0;
    res.status = swq_pkg::ST_NOTFOUND;
    tp = (req.operation == swq_pkg::OP_REMOVE) ? sr.hit_head : req.process;
    nx = pnext[tp];
    pv = pprev[tp];
    is_h = sr.hit_head == tp;
    is_t = sr.hit_tail == tp;
    do_unlink = 1'b0;
    do_ins = 1'b0;
    case (req.operation)
      swq_pkg::OP_INSERT: begin
        if (req.key != '0 && !pblk[req.process]) begin
          if (sr.hit) begin
            do_ins = 1'b1;
            cmd.we = 1'b1; cmd.idx = sr.hit_idx;
            cmd.wr_tail = 1'b1; cmd.tail = req.process;
            res.status = swq_pkg::ST_OK;
          end else if (sr.free) begin
            do_ins = 1'b1;
            cmd.we = 1'b1; cmd.idx = sr.free_idx; cmd.set_used = 1'b1;
            cmd.key = req.key;
            cmd.wr_head = 1'b1; cmd.head = req.process;
            cmd.wr_tail = 1'b1; cmd.tail = req.process;
            res.status = swq_pkg::ST_OK;
          end else begin
            res.status = swq_pkg::ST_FULL;
          end
        end
      end
      swq_pkg::OP_REMOVE, swq_pkg::OP_OUT: begin
        if (sr.hit && (req.operation == swq_pkg::OP_REMOVE || pblk[req.process])) begin
          do_unlink = 1'b1;
          res.status = swq_pkg::ST_OK;
          res.process_out = tp;
          res.key_out = skey;
          cmd.we = 1'b1; cmd.idx = sr.hit_idx;
          if (is_h && is_t) cmd.clr_used = 1'b1;
          else begin
            cmd.wr_head = is_h; cmd.head = nx;
            cmd.wr_tail = is_t; cmd.tail = pv;
          end
        end
      end
      swq_pkg::OP_HEAD: begin
        if (sr.hit) begin
          res.status = swq_pkg::ST_OK;
          res.process_out = sr.hit_head;
        end
      end
      default: ;
    endcase
    if (!exec_go) cmd.we = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      pblk      <= '0;
    end else begin
      if (exec_go) out_valid <= 1'b1;
      else if (out_valid && !out_stall) out_valid <= 1'b0;
      case (state)
        S_IDLE: if (accept) state <= S_LOOK;
        S_LOOK: state <= S_EXEC;
        S_EXEC: begin
          if (exec_go) begin
            state <= S_IDLE;
            if (do_ins) pblk[req.process] <= 1'b1;
            if (do_unlink) pblk[tp] <= 1'b0;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) req <= in_data;
    if (state == S_LOOK) begin
      skey <= (req.operation == swq_pkg::OP_OUT) ?
              (pblk[req.process] ? pwkey[req.process] : '0) : req.key;
    end
    if (exec_go) begin
      out_data <= res;
      if (do_ins) begin
        pnext[req.process] <= req.process;
        pwkey[req.process] <= req.key;
        if (sr.hit) begin
          pnext[sr.hit_tail] <= req.process;
          pprev[req.process] <= sr.hit_tail;
        end
      end
      if (do_unlink && !(is_h && is_t)) begin
        if (!is_h) pnext[pv] <= nx;
        if (!is_t) pprev[nx] <= pv;
      end
    end
  end

  `SWQ_ASSERT_NXT(a_accept_seq, clk, rst, accept, state == S_LOOK, "accept did not start lookup")
  `SWQ_ASSERT_NXT(a_exec_out, clk, rst, state == S_EXEC, out_valid, "no result after execute")
  `SWQ_ASSERT_NXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(out_data), "stalled result changed")
endmodule
